// File: src/uv_sphere_vertex_generator_defines.svh
// Assertion macros shared by the checker of the UV sphere vertex generator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define USVG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define USVG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/usvg_pkg.sv
// Shared types, constants and helper functions of the UV sphere vertex generator.
// Depends on nothing; used by the top level and by its checker.
`timescale 1ns / 1ps

package usvg_pkg;

    localparam int SEG_BITS_DEF = 8;

    // Register map of the configuration port.
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_RADIUS   = 1'd0;
    localparam logic [CFG_AW-1:0] REG_SEGMENTS = 1'd1;

    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [7:0]  SEG_RST    = 8'd16;

    // Fraction bits of the shared quotient col * 2^FRAC_BITS / segments.
    localparam int FRAC_BITS  = 19;
    localparam int DIV_PER_ST = 4;
    localparam int DIV_ST     = (FRAC_BITS + DIV_PER_ST - 1) / DIV_PER_ST;

    localparam int CORD_ITERS  = 16;
    localparam int CORD_PER_ST = 2;
    localparam int CORD_ST     = CORD_ITERS / CORD_PER_ST;

    // Edges from the accepting edge to the edge that loads the result.
    localparam int LATENCY = DIV_ST + CORD_ST + 6;

    localparam logic signed [31:0] CORDIC_ONE = 32'sd652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [17:0] z;
        logic [1:0]         quad;
    } cordic_t;

    typedef struct packed {
        logic        bad;
        logic        qvalid;
        logic [15:0] first;
        logic [15:0] below;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

    // Rotation angles in units of 2^-16 quarter turn.
    function automatic logic signed [17:0] atan_val(input int i);
        logic signed [17:0] a;
        case (i)
            0:       a = 18'sd32768;
            1:       a = 18'sd19344;
            2:       a = 18'sd10221;
            3:       a = 18'sd5188;
            4:       a = 18'sd2604;
            5:       a = 18'sd1303;
            6:       a = 18'sd652;
            7:       a = 18'sd326;
            8:       a = 18'sd163;
            9:       a = 18'sd81;
            10:      a = 18'sd41;
            11:      a = 18'sd20;
            12:      a = 18'sd10;
            13:      a = 18'sd5;
            14:      a = 18'sd3;
            default: a = 18'sd1;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] clamp_norm(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd16384)
            r = 16'sd16384;
        else if (v < -32'sd16384)
            r = -16'sd16384;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [16:0] clamp_pos(input logic signed [48:0] v);
        logic signed [16:0] r;
        if (v > 49'sd65535)
            r = 17'sd65535;
        else if (v < -49'sd65535)
            r = -17'sd65535;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

// File: src/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: grid point in, vertex position, normal, uv and quad indices out.
// Throughput: one grid point per cycle; busy is always low and the receiver cannot stall.
// On its way to the result strobe done a point passes a 6-stage restoring divider (entry bit,
// then up to 4 bits a stage), a phase stage, two 8-stage CORDICs and the quadrant, product,
// rounding, radius and output stages.
// Reset clears every valid bit and loads radius 1.0 and 16 segments. Depends on usvg_pkg.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator #(
    parameter int SEG_BITS = usvg_pkg::SEG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    grid_col,
    input  logic [7:0]                    grid_row,
    input  logic                          cfg_we,
    input  logic [usvg_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [15:0]                   cfg_wdata,
    output logic                          done,
    output logic signed [16:0]            pos_x,
    output logic signed [16:0]            pos_y,
    output logic signed [16:0]            pos_z,
    output logic signed [15:0]            norm_x,
    output logic signed [15:0]            norm_y,
    output logic signed [15:0]            norm_z,
    output logic [16:0]                   tex_u,
    output logic [16:0]                   tex_v,
    output logic [15:0]                   quad_first,
    output logic [15:0]                   quad_below,
    output logic                          quad_valid,
    output logic                          bad_index
);

    localparam int SW       = (SEG_BITS < 8) ? SEG_BITS : 8;
    localparam int RW       = SW + 1;
    localparam int QW       = usvg_pkg::FRAC_BITS + 1;
    localparam int DIV_ST   = usvg_pkg::DIV_ST;
    localparam int CORD_ST  = usvg_pkg::CORD_ST;
    // Side data from the phase stage to the last product stage.
    localparam int SIDE_LEN = CORD_ST + 5;
    localparam int IDX_Q    = CORD_ST + 1;
    localparam int IDX_M    = CORD_ST + 2;
    localparam int IDX_R    = CORD_ST + 3;
    localparam int IDX_P2   = CORD_ST + 4;

    // Configuration registers
    logic [15:0] radius_reg;
    logic [7:0]  seg_reg;
    logic [SW-1:0] seg_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= usvg_pkg::RADIUS_RST;
            seg_reg    <= usvg_pkg::SEG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                usvg_pkg::REG_RADIUS:   radius_reg <= cfg_wdata;
                usvg_pkg::REG_SEGMENTS: seg_reg    <= cfg_wdata[7:0];
                default:                ;
            endcase
        end
    end

    assign seg_m = seg_reg[SW-1:0];
    assign busy  = 1'b0;

    // Divider: entry stage does the leading quotient bit, then up to four bits a stage.
    logic            dv_reg   [DIV_ST+1];
    logic [SW-1:0]   col_reg  [DIV_ST+1];
    logic [SW-1:0]   row_reg  [DIV_ST+1];
    logic [RW-1:0]   rc_reg   [DIV_ST+1];
    logic [RW-1:0]   rr_reg   [DIV_ST+1];
    logic [QW-1:0]   qc_reg   [DIV_ST+1];
    logic [QW-1:0]   qr_reg   [DIV_ST+1];
    logic [RW-1:0]   rc_next  [DIV_ST+1];
    logic [RW-1:0]   rr_next  [DIV_ST+1];
    logic [QW-1:0]   qc_next  [DIV_ST+1];
    logic [QW-1:0]   qr_next  [DIV_ST+1];

    always_comb
    begin
        logic [SW-1:0] cm;
        logic [SW-1:0] rm;
        logic [RW-1:0] rc;
        logic [RW-1:0] rr;
        logic [RW-1:0] sh;
        logic [QW-1:0] qc;
        logic [QW-1:0] qr;
        cm = grid_col[SW-1:0];
        rm = grid_row[SW-1:0];
        rc_next[0] = (cm >= seg_m) ? RW'(cm - seg_m) : RW'(cm);
        qc_next[0] = QW'(cm >= seg_m);
        rr_next[0] = (rm >= seg_m) ? RW'(rm - seg_m) : RW'(rm);
        qr_next[0] = QW'(rm >= seg_m);
        for (int k = 1; k <= DIV_ST; k++)
        begin
            rc = rc_reg[k-1];
            qc = qc_reg[k-1];
            rr = rr_reg[k-1];
            qr = qr_reg[k-1];
            for (int j = 0; j < usvg_pkg::DIV_PER_ST; j++)
            begin
                if ((k - 1) * usvg_pkg::DIV_PER_ST + j < usvg_pkg::FRAC_BITS)
                begin
                    sh = {rc[RW-2:0], 1'b0};
                    if (sh >= RW'(seg_m))
                    begin
                        rc = sh - RW'(seg_m);
                        qc = {qc[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rc = sh;
                        qc = {qc[QW-2:0], 1'b0};
                    end
                    sh = {rr[RW-2:0], 1'b0};
                    if (sh >= RW'(seg_m))
                    begin
                        rr = sh - RW'(seg_m);
                        qr = {qr[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rr = sh;
                        qr = {qr[QW-2:0], 1'b0};
                    end
                end
            end
            rc_next[k] = rc;
            qc_next[k] = qc;
            rr_next[k] = rr;
            qr_next[k] = qr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_ST; k++)
                dv_reg[k] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= start && !busy;
            for (int k = 1; k <= DIV_ST; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg[0] <= grid_col[SW-1:0];
        row_reg[0] <= grid_row[SW-1:0];
        for (int k = 1; k <= DIV_ST; k++)
        begin
            col_reg[k] <= col_reg[k-1];
            row_reg[k] <= row_reg[k-1];
        end
        for (int k = 0; k <= DIV_ST; k++)
        begin
            rc_reg[k] <= rc_next[k];
            rr_reg[k] <= rr_next[k];
            qc_reg[k] <= qc_next[k];
            qr_reg[k] <= qr_next[k];
        end
    end

    // Phase stage: round the quotients into phases and uv, work out the quad indices.
    usvg_pkg::side_t   side_next;
    usvg_pkg::cordic_t cth_next;
    usvg_pkg::cordic_t cph_next;

    always_comb
    begin
        logic [QW-1:0] f;
        logic [QW-1:0] g;
        logic [QW:0]   t_th;
        logic [QW-1:0] t_ph;
        logic [QW-2:0] t_u;
        logic [QW-2:0] t_v;
        logic [SW-1:0] c;
        logic [SW-1:0] r;
        logic [31:0]   first_w;
        f = qc_reg[DIV_ST];
        g = qr_reg[DIV_ST];
        c = col_reg[DIV_ST];
        r = row_reg[DIV_ST];
        t_th = {1'b0, f} + 1'b1;
        t_ph = {1'b0, g[QW-1:1]} + 1'b1;
        t_u  = {1'b0, f[QW-1:2]} + 1'b1;
        t_v  = {1'b0, g[QW-1:2]} + 1'b1;
        first_w = 32'(r) * (32'(seg_m) + 32'd1) + 32'(c);
        side_next.bad    = (seg_m == '0) || (c > seg_m) || (r > seg_m);
        side_next.qvalid = (c < seg_m) && (r < seg_m);
        side_next.first  = side_next.qvalid ? first_w[15:0] : 16'd0;
        side_next.below  = side_next.qvalid ? (first_w[15:0] + 16'(seg_m) + 16'd1) : 16'd0;
        side_next.tex_u  = t_u[17:1];
        side_next.tex_v  = t_v[17:1];
        cth_next.x    = usvg_pkg::CORDIC_ONE;
        cth_next.y    = '0;
        cth_next.z    = {2'b00, t_th[16:1]};
        cth_next.quad = t_th[18:17];
        cph_next.x    = usvg_pkg::CORDIC_ONE;
        cph_next.y    = '0;
        cph_next.z    = {2'b00, t_ph[16:1]};
        cph_next.quad = t_ph[18:17];
    end

    // Side data and valid bits run alongside the CORDIC and the product stages.
    logic             sv_reg   [SIDE_LEN];
    usvg_pkg::side_t  side_reg [SIDE_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE_LEN; k++)
                sv_reg[k] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= dv_reg[DIV_ST];
            for (int k = 1; k < SIDE_LEN; k++)
                sv_reg[k] <= sv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < SIDE_LEN; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // Two CORDIC pipelines: unit 0 for theta, unit 1 for phi.
    usvg_pkg::cordic_t cor_reg  [2][CORD_ST+1];
    usvg_pkg::cordic_t cor_next [2][CORD_ST+1];

    always_comb
    begin
        usvg_pkg::cordic_t  cv;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        cor_next[0][0] = cth_next;
        cor_next[1][0] = cph_next;
        for (int u = 0; u < 2; u++)
        begin
            for (int s = 1; s <= CORD_ST; s++)
            begin
                cv = cor_reg[u][s-1];
                for (int j = 0; j < usvg_pkg::CORD_PER_ST; j++)
                begin
                    dx = $signed(cv.y) >>> ((s - 1) * usvg_pkg::CORD_PER_ST + j);
                    dy = $signed(cv.x) >>> ((s - 1) * usvg_pkg::CORD_PER_ST + j);
                    if (!cv.z[17])
                    begin
                        cv.x = cv.x - dx;
                        cv.y = cv.y + dy;
                        cv.z = cv.z - usvg_pkg::atan_val((s - 1) * usvg_pkg::CORD_PER_ST + j);
                    end
                    else
                    begin
                        cv.x = cv.x + dx;
                        cv.y = cv.y - dy;
                        cv.z = cv.z + usvg_pkg::atan_val((s - 1) * usvg_pkg::CORD_PER_ST + j);
                    end
                end
                cor_next[u][s] = cv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int u = 0; u < 2; u++)
            for (int s = 0; s <= CORD_ST; s++)
                cor_reg[u][s] <= cor_next[u][s];
    end

    // Quadrant stage
    logic signed [31:0] ct_reg, st_reg, cp_reg, sp_reg;
    logic signed [31:0] ct_next, st_next, cp_next, sp_next;

    always_comb
    begin
        usvg_pkg::cordic_t a;
        usvg_pkg::cordic_t b;
        a = cor_reg[0][CORD_ST];
        b = cor_reg[1][CORD_ST];
        case (a.quad)
            2'd0:    begin ct_next = a.x;  st_next = a.y;  end
            2'd1:    begin ct_next = -a.y; st_next = a.x;  end
            2'd2:    begin ct_next = -a.x; st_next = -a.y; end
            default: begin ct_next = a.y;  st_next = -a.x; end
        endcase
        case (b.quad)
            2'd0:    begin cp_next = b.x;  sp_next = b.y;  end
            2'd1:    begin cp_next = -b.y; sp_next = b.x;  end
            2'd2:    begin cp_next = -b.x; sp_next = -b.y; end
            default: begin cp_next = b.y;  sp_next = -b.x; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ct_reg <= ct_next;
        st_reg <= st_next;
        cp_reg <= cp_next;
        sp_reg <= sp_next;
    end

    // Product stage: sin phi times cos theta and sin theta, exact.
    logic signed [63:0] px_reg, pz_reg;
    logic signed [31:0] cpm_reg;

    always_ff @(posedge clk)
    begin
        px_reg  <= sp_reg * ct_reg;
        pz_reg  <= sp_reg * st_reg;
        cpm_reg <= cp_reg;
    end

    // Rounding stage: Q1.14 normals and Q2.30 values for the radius product.
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [15:0] nx_next, ny_next, nz_next;
    logic signed [31:0] n30x_reg, n30y_reg, n30z_reg;
    logic signed [31:0] n30x_next, n30z_next;

    always_comb
    begin
        logic signed [63:0] tx;
        logic signed [63:0] tz;
        logic signed [63:0] ux;
        logic signed [63:0] uz;
        logic signed [31:0] ty;
        tx = (px_reg + 64'sd35184372088832) >>> 46;
        tz = (pz_reg + 64'sd35184372088832) >>> 46;
        ux = (px_reg + 64'sd536870912) >>> 30;
        uz = (pz_reg + 64'sd536870912) >>> 30;
        ty = (cpm_reg + 32'sd32768) >>> 16;
        nx_next   = usvg_pkg::clamp_norm(tx[31:0]);
        nz_next   = usvg_pkg::clamp_norm(tz[31:0]);
        ny_next   = usvg_pkg::clamp_norm(ty);
        n30x_next = ux[31:0];
        n30z_next = uz[31:0];
    end

    always_ff @(posedge clk)
    begin
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        nz_reg   <= nz_next;
        n30x_reg <= n30x_next;
        n30y_reg <= cpm_reg;
        n30z_reg <= n30z_next;
    end

    // Radius stage
    logic signed [48:0] rx_reg, ry_reg, rz_reg;
    logic signed [15:0] nx2_reg, ny2_reg, nz2_reg;
    logic signed [16:0] rad_s;

    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        rx_reg  <= rad_s * n30x_reg;
        ry_reg  <= rad_s * n30y_reg;
        rz_reg  <= rad_s * n30z_reg;
        nx2_reg <= nx_reg;
        ny2_reg <= ny_reg;
        nz2_reg <= nz_reg;
    end

    // Output stage: round, saturate, and zero every field of an out of range point.
    logic               done_reg, qv_reg, bad_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [16:0]        tex_u_reg, tex_v_reg;
    logic [15:0]        first_reg, below_reg;
    logic signed [16:0] pos_x_next, pos_y_next, pos_z_next;
    usvg_pkg::side_t    sd;

    assign sd = side_reg[IDX_P2];

    always_comb
    begin
        logic signed [48:0] px;
        logic signed [48:0] py;
        logic signed [48:0] pz;
        px = (rx_reg + 49'sd536870912) >>> 30;
        py = (ry_reg + 49'sd536870912) >>> 30;
        pz = (rz_reg + 49'sd536870912) >>> 30;
        pos_x_next = usvg_pkg::clamp_pos(px);
        pos_y_next = usvg_pkg::clamp_pos(py);
        pos_z_next = usvg_pkg::clamp_pos(pz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            qv_reg   <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= sv_reg[IDX_P2];
            qv_reg   <= sv_reg[IDX_P2] && !sd.bad && sd.qvalid;
            bad_reg  <= sv_reg[IDX_P2] && sd.bad;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg  <= sd.bad ? 17'sd0 : pos_x_next;
        pos_y_reg  <= sd.bad ? 17'sd0 : pos_y_next;
        pos_z_reg  <= sd.bad ? 17'sd0 : pos_z_next;
        norm_x_reg <= sd.bad ? 16'sd0 : nx2_reg;
        norm_y_reg <= sd.bad ? 16'sd0 : ny2_reg;
        norm_z_reg <= sd.bad ? 16'sd0 : nz2_reg;
        tex_u_reg  <= sd.bad ? 17'd0 : sd.tex_u;
        tex_v_reg  <= sd.bad ? 17'd0 : sd.tex_v;
        first_reg  <= sd.bad ? 16'd0 : sd.first;
        below_reg  <= sd.bad ? 16'd0 : sd.below;
    end

    assign done       = done_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign norm_x     = norm_x_reg;
    assign norm_y     = norm_y_reg;
    assign norm_z     = norm_z_reg;
    assign tex_u      = tex_u_reg;
    assign tex_v      = tex_v_reg;
    assign quad_first = first_reg;
    assign quad_below = below_reg;
    assign quad_valid = qv_reg;
    assign bad_index  = bad_reg;

    // The quadrant, product and rounding stages keep their valid bits in sv_reg.
    logic unused_valid;
    assign unused_valid = sv_reg[IDX_Q] ^ sv_reg[IDX_M] ^ sv_reg[IDX_R];

endmodule

// File: src/usvg_chk.sv
// Port-level checker of the UV sphere vertex generator, bound to the top level.
// Depends on usvg_pkg and on uv_sphere_vertex_generator_defines.svh.
`timescale 1ns / 1ps
`include "uv_sphere_vertex_generator_defines.svh"

module usvg_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               quad_valid,
    input logic               bad_index,
    input logic signed [16:0] pos_x,
    input logic signed [15:0] norm_y,
    input logic [16:0]        tex_u
);

    // The look-back runs from the sampled strobe, past the edge that loaded it, to the accepting transfer.
    `USVG_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    `USVG_ASSERT_IMPLIES(a_done_has_transfer, clk, rst_n, done, $past(start && !busy, usvg_pkg::LATENCY + 1), "result without an accepted transfer")
    `USVG_ASSERT_IMPLIES(a_bad_zero, clk, rst_n, done && bad_index, !quad_valid && pos_x == 0 && norm_y == 0 && tex_u == 0, "out of range point with non-zero fields")
    `USVG_ASSERT_IMPLIES(a_flags_strobed, clk, rst_n, !done, !quad_valid && !bad_index, "flag raised without strobe")

endmodule

bind uv_sphere_vertex_generator usvg_chk u_usvg_chk (.*);

// File: verif/uv_sphere_vertex_generator_tb.sv
// Self-checking testbench for the UV sphere vertex generator: drives grid points with random
// gaps, predicts each vertex with a fixed-point CORDIC model and compares every done strobe.
// Depends on usvg_pkg and uv_sphere_vertex_generator.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_tb;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } point_t;

    typedef struct packed {
        logic signed [16:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic [16:0] tu, tv;
        logic [15:0] first, below;
        logic qv, bad;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [7:0] grid_col = '0;
    logic [7:0] grid_row = '0;
    logic cfg_we = 1'b0;
    logic [usvg_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic done;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [16:0] tex_u, tex_v;
    logic [15:0] quad_first, quad_below;
    logic quad_valid, bad_index;

    uv_sphere_vertex_generator DUT (.*);

    point_t  pending_points[$];
    vertex_t expected_vertices[$];
    logic [15:0] radius_q88 = usvg_pkg::RADIUS_RST;
    logic [7:0]  segments = usvg_pkg::SEG_RST;
    int gap_left = 0;
    bit gaps_on = 1'b1;
    int failures = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Phase in units of 2^-18 turn; returns cosine and sine in Q2.30.
    function automatic void cordic_sincos(input longint phase, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy;
        int q;
        q = int'((phase >> 16) & 3);
        z = phase & 16'hFFFF;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(usvg_pkg::atan_val(i));
            end else begin
                x += dx; y -= dy; z += longint'(usvg_pkg::atan_val(i));
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic vertex_t predict_vertex(point_t p);
        vertex_t v;
        longint seg, col, row, ct, st, cp, sp, n30[3], nq[3], pp;
        v = '0;
        seg = segments;
        col = p.col;
        row = p.row;
        if (seg == 0 || col > seg || row > seg) begin
            v.bad = 1'b1;
            return v;
        end
        cordic_sincos(((2 * col * (1 << 18) + seg) / (2 * seg)) & 18'h3FFFF, ct, st);
        cordic_sincos(((2 * row * (1 << 17) + seg) / (2 * seg)) & 18'h3FFFF, cp, sp);
        nq[0] = round_shift(sp * ct, 46);
        nq[1] = round_shift(cp, 16);
        nq[2] = round_shift(sp * st, 46);
        n30[0] = round_shift(sp * ct, 30);
        n30[1] = cp;
        n30[2] = round_shift(sp * st, 30);
        pp = clip(round_shift(longint'(radius_q88) * n30[0], 30), 65535); v.px = pp[16:0];
        pp = clip(round_shift(longint'(radius_q88) * n30[1], 30), 65535); v.py = pp[16:0];
        pp = clip(round_shift(longint'(radius_q88) * n30[2], 30), 65535); v.pz = pp[16:0];
        pp = clip(nq[0], 16384); v.nx = pp[15:0];
        pp = clip(nq[1], 16384); v.ny = pp[15:0];
        pp = clip(nq[2], 16384); v.nz = pp[15:0];
        pp = (2 * col * 65536 + seg) / (2 * seg); v.tu = pp[16:0];
        pp = (2 * row * 65536 + seg) / (2 * seg); v.tv = pp[16:0];
        if (col < seg && row < seg) begin
            pp = row * (seg + 1) + col;
            v.first = pp[15:0];
            pp = pp + seg + 1;
            v.below = pp[15:0];
            v.qv = 1'b1;
        end
        return v;
    endfunction

    // Driver: one transfer per start edge, with random bursts of idle cycles.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_vertices.insert(expected_vertices.size(),
                                         predict_vertex(point_t'{grid_col, grid_row}));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if ((!start || !busy) && pending_points.size() > 0) begin
                if (gaps_on && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(1, 17) - 1;
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    {grid_col, grid_row} <= pending_points.pop_front();
                end
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    // Monitor: the receiver cannot stall, so every done cycle is a transfer.
    always @(posedge clk) begin
        vertex_t e;
        if (rst_n && done) begin
            if (expected_vertices.size() == 0) begin
                $error("result transfer with no vertex expected");
                failures++;
            end else begin
                e = expected_vertices.pop_front();
                compare_field("pos_x", e.px, pos_x);
                compare_field("pos_y", e.py, pos_y);
                compare_field("pos_z", e.pz, pos_z);
                compare_field("norm_x", e.nx, norm_x);
                compare_field("norm_y", e.ny, norm_y);
                compare_field("norm_z", e.nz, norm_z);
                compare_field("tex_u", e.tu, tex_u);
                compare_field("tex_v", e.tv, tex_v);
                compare_field("quad_first", e.first, quad_first);
                compare_field("quad_below", e.below, quad_below);
                compare_field("quad_valid", e.qv, quad_valid);
                compare_field("bad_index", e.bad, bad_index);
            end
        end
    end

    task automatic queue_point(logic [7:0] c, logic [7:0] r);
        pending_points.insert(pending_points.size(), point_t'{c, r});
    endtask

    task automatic drain_pipeline();
        while (pending_points.size() > 0 || start || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (usvg_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // The write enable drops for a cycle so that back-to-back writes never collide.
    task automatic write_register(logic [usvg_pkg::CFG_AW-1:0] idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == usvg_pkg::REG_RADIUS)
            radius_q88 = value;
        else
            segments = value[7:0];
        @(posedge clk);
    endtask

    // Mostly in-range points, with some on the last column and some anywhere at all.
    task automatic queue_random_points(int n);
        int s;
        s = segments;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: queue_point(8'($urandom), 8'($urandom));
                1: queue_point(8'(s), 8'($urandom_range(0, s)));
                default: queue_point(8'($urandom_range(0, s)), 8'($urandom_range(0, s)));
            endcase
        end
    endtask

    initial begin
        logic [7:0] seg_set[7] = '{8'd255, 8'd1, 8'd7, 8'd64, 8'd3, 8'd128, 8'd200};
        logic [15:0] rad_set[7] = '{16'd65535, 16'd1, 16'd256, 16'd40000, 16'd777,
                                    16'd65535, 16'd12345};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed points at reset settings: corners, poles, edge and out of range.
        queue_point(8'd0, 8'd0);
        queue_point(8'd16, 8'd16);
        queue_point(8'd15, 8'd15);
        queue_point(8'd4, 8'd8);
        queue_point(8'd12, 8'd3);
        queue_point(8'd17, 8'd0);
        queue_point(8'd0, 8'd17);
        queue_point(8'd255, 8'd255);
        queue_point(8'd16, 8'd5);
        queue_point(8'd170, 8'd85);
        drain_pipeline();
        // Zero segment count: everything is out of range.
        write_register(usvg_pkg::REG_SEGMENTS, 16'd0);
        queue_point(8'd0, 8'd0);
        queue_point(8'd1, 8'd0);
        drain_pipeline();
        for (int ph = 0; ph < 7; ph++) begin
            write_register(usvg_pkg::REG_RADIUS, rad_set[ph]);
            write_register(usvg_pkg::REG_SEGMENTS, {8'($urandom), seg_set[ph]});
            queue_point(segments, segments);
            queue_point(8'd0, segments);
            queue_random_points(190);
            if (ph == 6)
                gaps_on = 1'b0;
            drain_pipeline();
        end
        if (failures == 0) begin
            $display("uv_sphere_vertex_generator_tb: PASS");
        end else begin
            $display("uv_sphere_vertex_generator_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("uv_sphere_vertex_generator_tb: FAIL");
        $finish;
    end
endmodule

// File: uv_sphere_vertex_generator.f
+incdir+src
src/usvg_pkg.sv
src/uv_sphere_vertex_generator.sv
src/usvg_chk.sv
verif/uv_sphere_vertex_generator_tb.sv
